// ----- hw/rtl/tcw_pkg.sv -----
// Shared types, constants and codes for the text console character writer.
package tcw_pkg;

    // Default geometry of the cell store
    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;

    // Configuration register indexes and reset values
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 1'b1;
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    // Function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Cell layout: color in the high byte, character in the low byte
    localparam int CELL_W = 16;

    typedef struct packed {
        logic        func;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [12:0] cell_addr;
    } in_word_t;

    typedef struct packed {
        logic [12:0] cursor_offset;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT_DECIDE,
        ST_WRITE_ADDR,
        ST_WRITE_CHAR,
        ST_FILL_ADDR,
        ST_FILL_READ,
        ST_FILL_CHECK,
        ST_SCROLL_INIT,
        ST_SCROLL_COPY,
        ST_SCROLL_CLEAR,
        ST_READ_ISSUE,
        ST_READ_DONE,
        ST_DONE
    } tcw_state_t;

    // Where to continue once a scroll is finished
    typedef enum logic {
        CONT_FILL,
        CONT_WRITE
    } tcw_cont_t;

endpackage

// ----- hw/rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tcw_muladd.sv -----
// Shared multiply-add unit: q = a * b + c, registered.
module tcw_muladd #(
    parameter int AW_IN = 7,
    parameter int BW_IN = 8,
    parameter int QW    = 14
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW_IN-1:0] a,
    input  logic [BW_IN-1:0] b,
    input  logic [BW_IN-1:0] c,
    output logic [QW-1:0]    q
);

    localparam int PW = AW_IN + BW_IN + 1;

    logic [PW-1:0] sum;
    logic [QW-1:0] q_reg;

    // Form the product and the addend at full width
    always_comb
    begin
        sum = PW'(a) * PW'(b) + PW'(c);
    end

    // Hold the result until the next operation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= QW'(sum);
        end
    end

    assign q = q_reg;

endmodule

// ----- hw/rtl/tcw_seq.sv -----
// Sequencer: cursor, put/read/scroll steps, clearing pass and output register.
module tcw_seq #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
    localparam int CW    = $clog2(MAX_COLS + 1),
    localparam int RW    = $clog2(MAX_ROWS + 1),
    localparam int DEPTH = MAX_COLS * MAX_ROWS,
    localparam int OW    = $clog2(DEPTH + 1),
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CW-1:0]             nc,
    input  logic [RW-1:0]             nr,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tcw_pkg::in_word_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tcw_pkg::out_word_t        out_data,
    output logic                      mul_en,
    output logic [RW-1:0]             mul_a,
    output logic [CW-1:0]             mul_b,
    output logic [CW-1:0]             mul_c,
    input  logic [OW-1:0]             mul_q,
    output logic                      ram_we,
    output logic [AW-1:0]             ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] ram_wdata,
    output logic                      ram_re,
    output logic [AW-1:0]             ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

    tcw_pkg::tcw_state_t state_reg, state_next;
    tcw_pkg::tcw_cont_t  cont_reg, cont_next;
    tcw_pkg::in_word_t   in_reg, in_next;
    tcw_pkg::out_word_t  out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [OW-1:0]       cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic [7:0]          rchar_reg, rchar_next;
    logic [7:0]          rcolor_reg, rcolor_next;

    logic [CW-1:0] nc_m1;
    logic [RW-1:0] nr_m1;
    logic          in_fire;
    logic          is_bs;
    logic          is_nl;
    logic          rd_in_range;
    logic [OW-1:0] scroll_end;

    assign nc_m1       = nc - CW'(1);
    assign nr_m1       = nr - RW'(1);
    assign in_ready    = (state_reg == tcw_pkg::ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign is_bs       = (in_reg.char_code == tcw_pkg::CH_BACKSPACE);
    assign is_nl       = (in_reg.char_code == tcw_pkg::CH_NEWLINE);
    assign rd_in_range = (int'(in_reg.cell_addr) < DEPTH);
    assign scroll_end  = mul_q + OW'(nc);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cont_next      = cont_reg;
        in_next        = in_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rchar_next     = rchar_reg;
        rcolor_next    = rcolor_reg;

        mul_en    = 1'b0;
        mul_a     = row_reg;
        mul_b     = nc;
        mul_c     = col_reg;
        ram_we    = 1'b0;
        ram_waddr = AW'(mul_q);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = AW'(mul_q);

        // Drop the output word once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                // Zero the whole store, one cell a cycle
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_reg);
                if (cnt_reg == OW'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    in_next     = in_data;
                    rchar_next  = '0;
                    rcolor_next = '0;
                    if (in_data.func == tcw_pkg::FUNC_PUT)
                    begin
                        // Clamp a stale cursor to the area in use
                        row_next   = (row_reg > nr_m1) ? nr_m1 : row_reg;
                        col_next   = (col_reg > nc) ? nc : col_reg;
                        state_next = tcw_pkg::ST_PUT_DECIDE;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_READ_ISSUE;
                    end
                end
            end

            tcw_pkg::ST_PUT_DECIDE:
            begin
                if (is_bs)
                begin
                    // Step back, wrapping to the previous row; stay at top-left
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - CW'(1);
                    end
                    else if (row_reg != '0)
                    begin
                        col_next = nc_m1;
                        row_next = row_reg - RW'(1);
                    end
                    state_next = tcw_pkg::ST_FILL_ADDR;
                end
                else if ((col_reg == nc) || is_nl)
                begin
                    // Go to the start of the next row, scrolling at the bottom
                    col_next = '0;
                    if (row_reg == nr_m1)
                    begin
                        cont_next  = is_nl ? tcw_pkg::CONT_FILL : tcw_pkg::CONT_WRITE;
                        state_next = tcw_pkg::ST_SCROLL_INIT;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = is_nl ? tcw_pkg::ST_FILL_ADDR : tcw_pkg::ST_WRITE_ADDR;
                    end
                end
                else
                begin
                    state_next = tcw_pkg::ST_WRITE_ADDR;
                end
            end

            tcw_pkg::ST_WRITE_ADDR:
            begin
                mul_en     = 1'b1;
                state_next = tcw_pkg::ST_WRITE_CHAR;
            end

            tcw_pkg::ST_WRITE_CHAR:
            begin
                // Store character and color, then advance the column; after the last cell of the bottom row, scroll
                ram_we    = 1'b1;
                ram_wdata = {in_reg.color, in_reg.char_code};
                if ((row_reg == nr_m1) && ((col_reg + CW'(1)) == nc))
                begin
                    if (row_reg != '0)
                    begin
                        row_next = row_reg - RW'(1);
                        col_next = col_reg + CW'(1);
                    end
                    else
                    begin
                        col_next = '0;
                    end
                    cont_next  = tcw_pkg::CONT_FILL;
                    state_next = tcw_pkg::ST_SCROLL_INIT;
                end
                else
                begin
                    col_next   = col_reg + CW'(1);
                    state_next = tcw_pkg::ST_FILL_ADDR;
                end
            end

            tcw_pkg::ST_FILL_ADDR:
            begin
                mul_en     = 1'b1;
                state_next = tcw_pkg::ST_FILL_READ;
            end

            tcw_pkg::ST_FILL_READ:
            begin
                ram_re     = 1'b1;
                state_next = tcw_pkg::ST_FILL_CHECK;
            end

            tcw_pkg::ST_FILL_CHECK:
            begin
                // Give an empty cell the input color; backspace also clears the character
                if (is_bs)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {(ram_rdata[7:0] == 8'd0) ? in_reg.color : ram_rdata[15:8],
                                 8'd0};
                end
                else if (ram_rdata[7:0] == 8'd0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {in_reg.color, 8'd0};
                end
                state_next = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_SCROLL_INIT:
            begin
                // Cells to move: (rows - 1) * columns
                mul_en     = 1'b1;
                mul_a      = nr_m1;
                mul_c      = '0;
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = tcw_pkg::ST_SCROLL_COPY;
            end

            tcw_pkg::ST_SCROLL_COPY:
            begin
                // Read one row ahead, write the word back in the next cycle
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg < mul_q)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = AW'(cnt_reg + OW'(nc));
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(cnt_reg);
                    cnt_next       = cnt_reg + OW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = tcw_pkg::ST_SCROLL_CLEAR;
                    end
                end
            end

            tcw_pkg::ST_SCROLL_CLEAR:
            begin
                // Blank the last row in use
                ram_we    = 1'b1;
                ram_waddr = AW'(cnt_reg);
                if ((cnt_reg + OW'(1)) == scroll_end)
                begin
                    cnt_next   = '0;
                    state_next = (cont_reg == tcw_pkg::CONT_WRITE) ? tcw_pkg::ST_WRITE_ADDR
                                                                   : tcw_pkg::ST_FILL_ADDR;
                end
                else
                begin
                    cnt_next = cnt_reg + OW'(1);
                end
            end

            tcw_pkg::ST_READ_ISSUE:
            begin
                ram_re     = rd_in_range;
                ram_raddr  = AW'(in_reg.cell_addr);
                mul_en     = 1'b1;
                state_next = tcw_pkg::ST_READ_DONE;
            end

            tcw_pkg::ST_READ_DONE:
            begin
                if (rd_in_range)
                begin
                    rchar_next  = ram_rdata[7:0];
                    rcolor_next = ram_rdata[15:8];
                end
                state_next = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.cursor_offset = 13'(mul_q);
                    out_data_next.cell_char     = rchar_reg;
                    out_data_next.cell_color    = rcolor_reg;
                    state_next                  = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_CLEAR;
            cont_reg      <= tcw_pkg::CONT_FILL;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cont_reg      <= cont_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        out_data_reg  <= out_data_next;
        pend_addr_reg <= pend_addr_next;
        rchar_reg     <= rchar_next;
        rcolor_reg    <= rcolor_next;
    end

endmodule

// ----- hw/rtl/text_console_char_writer_unit.sv -----
// Top level of the text console character writer: config registers, cell store, shared unit.
//
// Text-mode console engine. It holds a store of MAX_COLS * MAX_ROWS cells (character in the
// low byte, color in the high byte) and a cursor, and handles one word at a time. A put word
// also sets off a scroll when the cursor runs off the last row: the scroll copies (rows - 1)
// * columns cells at one cell per cycle through the single store port pair, then clears
// columns cells. After reset the block runs a clearing pass over the whole store before it
// accepts the first word; configuration writes are taken throughout. The result register
// lets the next word enter while a result waits.
module text_console_char_writer_unit #(
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tcw_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tcw_pkg::out_word_t                out_data
);

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int OW    = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    columns_reg;
    logic [6:0]    rows_reg;
    logic [CW-1:0] nc;
    logic [RW-1:0] nr;

    logic                       mul_en;
    logic [RW-1:0]              mul_a;
    logic [CW-1:0]              mul_b;
    logic [CW-1:0]              mul_c;
    logic [OW-1:0]              mul_q;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tcw_pkg::COLUMNS_RESET;
            rows_reg    <= tcw_pkg::ROWS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tcw_pkg::CFG_COLUMNS: columns_reg <= cfg_data;
                tcw_pkg::CFG_ROWS:    rows_reg    <= cfg_data[6:0];
                default:              columns_reg <= columns_reg;
            endcase
        end
    end

    // Geometry in use: zero acts as one, large values saturate at the store size
    always_comb
    begin
        if (columns_reg == 8'd0)
        begin
            nc = CW'(1);
        end
        else if (int'(columns_reg) > MAX_COLS)
        begin
            nc = CW'(MAX_COLS);
        end
        else
        begin
            nc = CW'(columns_reg);
        end

        if (rows_reg == 7'd0)
        begin
            nr = RW'(1);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            nr = RW'(MAX_ROWS);
        end
        else
        begin
            nr = RW'(rows_reg);
        end
    end

    tcw_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .nc        (nc),
        .nr        (nr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mul_en    (mul_en),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_c     (mul_c),
        .mul_q     (mul_q),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_muladd #(
        .AW_IN (RW),
        .BW_IN (CW),
        .QW    (OW)
    ) u_muladd (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .c   (mul_c),
        .q   (mul_q)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the text console character writer: console model, driver, monitor.
module tb;

    localparam int STORE_CELLS = tcw_pkg::MAX_COLS_DEF * tcw_pkg::MAX_ROWS_DEF;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index = tcw_pkg::CFG_COLUMNS;
    logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    tcw_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    tcw_pkg::out_word_t out_data;

    // Console model state
    logic [15:0] screen_mem [STORE_CELLS];
    int unsigned crs_col;
    int unsigned crs_row;
    logic [7:0] geo_cols;
    logic [6:0] geo_rows;

    tcw_pkg::in_word_t console_words [$];
    tcw_pkg::out_word_t expected_reports [$];
    int unsigned words_issued = 0;
    int unsigned words_sent = 0;
    int unsigned reports_seen = 0;
    int unsigned err_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit hold_done = 1'b0;
    bit word_taken = 1'b0;

    text_console_char_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Effective geometry: zero acts as one, oversize saturates
    function automatic int unsigned act_cols();
        if (geo_cols == 8'd0)
            return 1;
        if (geo_cols > tcw_pkg::MAX_COLS_DEF)
            return tcw_pkg::MAX_COLS_DEF;
        return geo_cols;
    endfunction

    function automatic int unsigned act_rows();
        if (geo_rows == 7'd0)
            return 1;
        if (geo_rows > tcw_pkg::MAX_ROWS_DEF)
            return tcw_pkg::MAX_ROWS_DEF;
        return geo_rows;
    endfunction

    // Move the cursor, scrolling when it runs off the last cell, then fill an empty cell
    function automatic void place_cursor(int unsigned col, int unsigned row, logic [7:0] color);
        int unsigned nc;
        int unsigned nr;
        int unsigned base;
        int unsigned off;
        nc = act_cols();
        nr = act_rows();
        if (row * nc + col >= nr * nc)
        begin
            base = (nr - 1) * nc;
            for (int i = 0; i < base; i++)
                screen_mem[i] = screen_mem[i + nc];
            for (int i = base; i < base + nc; i++)
                screen_mem[i] = 16'h0000;
            if (row > 0)
                row--;
            else
                col = 0;
        end
        crs_col = col;
        crs_row = row;
        off = row * nc + col;
        if (screen_mem[off][7:0] == 8'h00)
            screen_mem[off] = {color, 8'h00};
    endfunction

    // Apply one console word to the model and return the report it produces
    function automatic tcw_pkg::out_word_t apply_console_word(tcw_pkg::in_word_t w);
        tcw_pkg::out_word_t r;
        int unsigned nc;
        int unsigned nr;
        int unsigned off;
        r = '0;
        nc = act_cols();
        nr = act_rows();
        if (w.func == tcw_pkg::FUNC_PUT)
        begin
            // clamp a cursor left stale by a geometry change
            if (crs_row > nr - 1)
                crs_row = nr - 1;
            if (crs_col > nc)
                crs_col = nc;
            if (w.char_code == tcw_pkg::CH_BACKSPACE)
            begin
                if (crs_col > 0)
                    place_cursor(crs_col - 1, crs_row, w.color);
                else if (crs_row > 0)
                    place_cursor(nc - 1, crs_row - 1, w.color);
                else
                    place_cursor(0, 0, w.color);
                off = crs_row * nc + crs_col;
                screen_mem[off][7:0] = 8'h00;
            end
            else
            begin
                if (crs_col > nc - 1 || w.char_code == tcw_pkg::CH_NEWLINE)
                    place_cursor(0, crs_row + 1, w.color);
                if (w.char_code != tcw_pkg::CH_NEWLINE)
                begin
                    off = crs_row * nc + crs_col;
                    screen_mem[off] = {w.color, w.char_code};
                    place_cursor(crs_col + 1, crs_row, w.color);
                end
            end
        end
        else
        begin
            r.cell_char  = screen_mem[w.cell_addr][7:0];
            r.cell_color = screen_mem[w.cell_addr][15:8];
        end
        r.cursor_offset = 13'(crs_row * act_cols() + crs_col);
        return r;
    endfunction

    function automatic void push_word(logic f, logic [7:0] ch, logic [7:0] color,
                                      logic [12:0] addr);
        tcw_pkg::in_word_t w;
        w.func      = f;
        w.char_code = ch;
        w.color     = color;
        w.cell_addr = addr;
        console_words.push_back(w);
        words_issued++;
    endfunction

    // Random word: text with newline (nl_pct percent), backspace and NUL mixed in, reads in between
    function automatic void push_random_word(int unsigned nl_pct);
        int unsigned roll;
        logic [7:0] ch;
        logic [12:0] addr;
        roll = $urandom_range(99);
        if (roll < nl_pct)
            ch = tcw_pkg::CH_NEWLINE;
        else if (roll < nl_pct + 8)
            ch = tcw_pkg::CH_BACKSPACE;
        else if (roll < nl_pct + 12)
            ch = 8'h00;
        else
            ch = 8'($urandom_range(255));
        if ($urandom_range(3) == 0)
            addr = 13'($urandom_range(STORE_CELLS - 1));
        else
            addr = 13'($urandom_range(act_cols() * act_rows() - 1));
        push_word(($urandom_range(99) < 30) ? tcw_pkg::FUNC_READ : tcw_pkg::FUNC_PUT, ch,
                  8'($urandom_range(255)), addr);
    endfunction

    // Wait until every issued word has reported, then let the block go quiet
    task automatic drain_reports();
        while (reports_seen != words_issued)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic set_geometry(logic [7:0] cols, logic [7:0] rows);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tcw_pkg::CFG_COLUMNS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= tcw_pkg::CFG_ROWS;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        geo_cols = cols;
        geo_rows = rows[6:0];
    endtask

    task automatic run_phase(logic [7:0] cols, logic [7:0] rows, int unsigned count,
                             int unsigned nl_pct);
        drain_reports();
        set_geometry(cols, rows);
        repeat (count) push_random_word(nl_pct);
    endtask

    // Sender: offer the next word at the falling edge, hold it until taken
    always @(negedge clk)
    begin
        if (!in_valid || word_taken)
        begin
            if (console_words.size() != 0 &&
                ((words_sent >= 300 && words_sent < 500) || $urandom_range(99) >= 35))
            begin
                in_data  <= console_words.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    // Receiver: random stalls, a quiet stretch and one long hold-off
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && reports_seen >= 700)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (reports_seen >= 300 && reports_seen < 500)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= 35);
        end
    end

    // Monitor: check reports against the model, predict accepted words, watch for a hang
    always @(posedge clk)
    begin
        tcw_pkg::out_word_t want;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    $error("report word with nothing expected: %h", out_data);
                    err_cnt++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_data.cursor_offset !== want.cursor_offset)
                    begin
                        $error("cursor_offset: expected %0d, got %0d",
                               want.cursor_offset, out_data.cursor_offset);
                        err_cnt++;
                    end
                    if (out_data.cell_char !== want.cell_char)
                    begin
                        $error("cell_char: expected %h, got %h",
                               want.cell_char, out_data.cell_char);
                        err_cnt++;
                    end
                    if (out_data.cell_color !== want.cell_color)
                    begin
                        $error("cell_color: expected %h, got %h",
                               want.cell_color, out_data.cell_color);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                word_taken = 1'b1;
                words_sent++;
                expected_reports.push_back(apply_console_word(in_data));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_CELLS; i++)
            screen_mem[i] = 16'h0000;
        crs_col  = 0;
        crs_row  = 0;
        geo_cols = tcw_pkg::COLUMNS_RESET;
        geo_rows = tcw_pkg::ROWS_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words on a 4 x 3 screen
        set_geometry(8'd4, 8'd3);
        // backspace at top-left
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, 8'h00, 13'h1FFF);
        push_word(tcw_pkg::FUNC_PUT, 8'hFF, 8'hFF, 13'h0000);
        // NUL keeps only the color
        push_word(tcw_pkg::FUNC_PUT, 8'h00, 8'h5A, 13'h0AAA);
        push_word(tcw_pkg::FUNC_PUT, 8'h41, 8'h07, 13'h1555);
        // cursor lands past the row
        push_word(tcw_pkg::FUNC_PUT, 8'h42, 8'h1E, 13'h0000);
        push_word(tcw_pkg::FUNC_READ, 8'hFF, 8'hFF, 13'h0004);
        // wraps to the next row
        push_word(tcw_pkg::FUNC_PUT, 8'h43, 8'h2F, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, 8'h11, 13'h0000);
        // wraps to end of row above
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_BACKSPACE, 8'h22, 13'h0000);
        push_word(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 13'h0003);
        push_word(tcw_pkg::FUNC_READ, 8'hFF, 8'h00, 13'h1FFF);
        push_word(tcw_pkg::FUNC_READ, 8'h00, 8'hFF, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NEWLINE, 8'h33, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NEWLINE, 8'h44, 13'h0000);
        // newline off the bottom scrolls
        push_word(tcw_pkg::FUNC_PUT, tcw_pkg::CH_NEWLINE, 8'h55, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, 8'h78, 8'h01, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, 8'h78, 8'h02, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, 8'h78, 8'h03, 13'h0000);
        push_word(tcw_pkg::FUNC_PUT, 8'h78, 8'h04, 13'h0000);
        // text off the bottom scrolled on the word above; this one wraps
        push_word(tcw_pkg::FUNC_PUT, 8'h79, 8'h80, 13'h0000);
        push_word(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 13'h0004);
        push_word(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 13'h0008);

        // Random phases; each waits for all reports before the geometry changes
        run_phase(8'd80, 8'd25, 150, 10);
        run_phase(8'd1, 8'd1, 100, 10);
        run_phase(8'd0, 8'd0, 60, 10);
        run_phase(8'd128, 8'd1, 100, 5);
        run_phase(8'd1, 8'hC0, 100, 10);
        run_phase(8'd7, 8'd5, 250, 12);
        run_phase(8'd16, 8'd8, 200, 10);
        run_phase(8'd255, 8'd127, 120, 85);
        run_phase(8'd5, 8'd3, 200, 10);
        run_phase(8'd3, 8'd2, 150, 10);
        drain_reports();

        if (err_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
